// ===== rtl/beacon_rssi_window_smoother_core_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef BEACON_RSSI_WINDOW_SMOOTHER_CORE_DEFINES_SVH
`define BEACON_RSSI_WINDOW_SMOOTHER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BRWS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brws same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BRWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brws next-cycle check failed");

`endif

// ===== rtl/brws_pkg.sv =====
package brws_pkg;

    localparam int HISTORY_DEPTH = 64;

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int PWR_W  = 16;
    localparam int TIME_W = 48;
    localparam int WIN_W  = 7;
    localparam int LOSS_W = PWR_W + 1;
    localparam int LSUM_W = LOSS_W + CNT_W;
    localparam int TSUM_W = TIME_W + CNT_W;
    localparam int DIV_W  = TSUM_W;
    localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic setup;
        logic walk;
        logic div_start;
        logic load_out;
    } brws_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_done;
        logic div_done;
    } brws_status_t;

endpackage

// ===== rtl/brws_div.sv =====
// Restoring divider, one quotient bit per cycle; two dividends share one divisor.
module brws_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [brws_pkg::CNT_W-1:0]  divisor,
    input  logic [brws_pkg::DIV_W-1:0]  dividend_a,
    input  logic [brws_pkg::DIV_W-1:0]  dividend_b,
    output logic [brws_pkg::DIV_W-1:0]  quot_a,
    output logic [brws_pkg::DIV_W-1:0]  quot_b,
    output logic                        done
);
    import brws_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  qa_reg, qb_reg;
    logic [CNT_W-1:0]  ra_reg, rb_reg;
    logic [CNT_W-1:0]  d_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;

    logic [CNT_W:0]    ra_sh, rb_sh;
    logic              ge_a, ge_b;

    always_comb
    begin
        ra_sh = {ra_reg, qa_reg[DIV_W-1]};
        rb_sh = {rb_reg, qb_reg[DIV_W-1]};
        ge_a  = ra_sh >= {1'b0, d_reg};
        ge_b  = rb_sh >= {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(DIV_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qa_reg <= dividend_a;
            qb_reg <= dividend_b;
            ra_reg <= '0;
            rb_reg <= '0;
            d_reg  <= divisor;
        end
        else if (run_reg)
        begin
            qa_reg <= {qa_reg[DIV_W-2:0], ge_a};
            qb_reg <= {qb_reg[DIV_W-2:0], ge_b};
            ra_reg <= ge_a ? CNT_W'(ra_sh - {1'b0, d_reg}) : ra_sh[CNT_W-1:0];
            rb_reg <= ge_b ? CNT_W'(rb_sh - {1'b0, d_reg}) : rb_sh[CNT_W-1:0];
        end
    end

    assign quot_a = qa_reg;
    assign quot_b = qb_reg;
    assign done   = done_reg;

endmodule

// ===== rtl/brws_dp.sv =====
`include "beacon_rssi_window_smoother_core_defines.svh"

module brws_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  brws_pkg::brws_cmd_t               cmd,
    output brws_pkg::brws_status_t            status,
    input  logic                              cfg_wr,
    input  logic [brws_pkg::WIN_W-1:0]        cfg_data,
    input  logic signed [brws_pkg::PWR_W-1:0] tx_pwr,
    input  logic signed [brws_pkg::PWR_W-1:0] rssi,
    input  logic [brws_pkg::TIME_W-1:0]       sample_time,
    output logic signed [brws_pkg::PWR_W-1:0] smoothed_rssi,
    output logic signed [brws_pkg::PWR_W-1:0] latest_tx_pwr,
    output logic [brws_pkg::TIME_W-1:0]       mean_time,
    output logic [brws_pkg::WIN_W-1:0]        samples_used
);
    import brws_pkg::*;

    localparam int SM_W = LOSS_W + 2;
    localparam logic signed [SM_W-1:0] SAT_HI = SM_W'(2 ** (PWR_W - 1) - 1);
    localparam logic signed [SM_W-1:0] SAT_LO = SM_W'(-(2 ** (PWR_W - 1)));

    // history
    logic signed [LOSS_W-1:0] loss_mem [HISTORY_DEPTH];
    logic [TIME_W-1:0]        time_mem [HISTORY_DEPTH];

    logic [WIN_W-1:0]         window_reg;
    logic [PTR_W-1:0]         wp_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PWR_W-1:0]  tx_reg;

    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         issued_reg;
    logic [PTR_W-1:0]         rd_idx_reg;
    logic                     rd_pend_reg;
    logic signed [LOSS_W-1:0] rd_loss_reg;
    logic [TIME_W-1:0]        rd_time_reg;
    logic signed [LSUM_W-1:0] lsum_reg;
    logic [TSUM_W-1:0]        tsum_reg;
    logic                     loss_neg_reg;

    logic signed [PWR_W-1:0]  smoothed_reg;
    logic signed [PWR_W-1:0]  latest_reg;
    logic [TIME_W-1:0]        mean_time_reg;
    logic [WIN_W-1:0]         used_reg;

    logic signed [LOSS_W-1:0] loss_in;
    logic [CNT_W-1:0]         n_sel;
    logic                     rd_en;
    logic [LSUM_W-1:0]        lsum_mag;
    logic [DIV_W-1:0]         quot_a, quot_b;
    logic                     div_done;
    logic signed [LOSS_W:0]   mloss;
    logic signed [SM_W-1:0]   smooth;
    logic signed [PWR_W-1:0]  smooth_sat;

    always_comb
    begin
        loss_in  = LOSS_W'(tx_pwr) - LOSS_W'(rssi);
        // window 0 or wider than the history: average everything stored
        if (window_reg == '0 || CMP_W'(window_reg) > CMP_W'(cnt_reg))
            n_sel = cnt_reg;
        else
            n_sel = CNT_W'(window_reg);
        rd_en    = cmd.walk && (issued_reg != n_reg);
        lsum_mag = lsum_reg[LSUM_W-1] ? LSUM_W'(-lsum_reg) : LSUM_W'(lsum_reg);
        status.walk_done = (issued_reg == n_reg) && !rd_pend_reg;
        status.div_done  = div_done;
        // mean loss truncates toward zero: divide magnitude, restore sign
        mloss = loss_neg_reg ? -$signed({1'b0, quot_b[LOSS_W-1:0]})
                             :  $signed({1'b0, quot_b[LOSS_W-1:0]});
        smooth = SM_W'(tx_reg) - SM_W'(mloss);
        if (smooth > SAT_HI)
            smooth_sat = PWR_W'(SAT_HI);
        else if (smooth < SAT_LO)
            smooth_sat = PWR_W'(SAT_LO);
        else
            smooth_sat = PWR_W'(smooth);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            wp_reg      <= '0;
            cnt_reg     <= '0;
            rd_pend_reg <= 1'b0;
            issued_reg  <= '0;
            n_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
                window_reg <= cfg_data;
            if (cmd.push)
            begin
                wp_reg <= (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (cnt_reg != CNT_W'(HISTORY_DEPTH))
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.setup)
            begin
                n_reg       <= n_sel;
                issued_reg  <= '0;
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.walk)
            begin
                rd_pend_reg <= rd_en;
                if (rd_en)
                    issued_reg <= issued_reg + 1'b1;
            end
        end
    end

    // history write and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            loss_mem[wp_reg] <= loss_in;
            time_mem[wp_reg] <= sample_time;
        end
        if (rd_en)
        begin
            rd_loss_reg <= loss_mem[rd_idx_reg];
            rd_time_reg <= time_mem[rd_idx_reg];
        end
    end

    // walk newest to oldest, accumulate in the cycle after each read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            tx_reg <= tx_pwr;
        if (cmd.setup)
        begin
            rd_idx_reg <= (wp_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1) : wp_reg - 1'b1;
            lsum_reg   <= '0;
            tsum_reg   <= '0;
        end
        else if (cmd.walk)
        begin
            if (rd_en)
                rd_idx_reg <= (rd_idx_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1)
                                                 : rd_idx_reg - 1'b1;
            if (rd_pend_reg)
            begin
                lsum_reg <= lsum_reg + LSUM_W'(rd_loss_reg);
                tsum_reg <= tsum_reg + TSUM_W'(rd_time_reg);
            end
        end
        if (cmd.div_start)
            loss_neg_reg <= lsum_reg[LSUM_W-1];
        if (cmd.load_out)
        begin
            smoothed_reg  <= smooth_sat;
            latest_reg    <= tx_reg;
            mean_time_reg <= quot_a[TIME_W-1:0];
            used_reg      <= WIN_W'(n_reg);
        end
    end

    brws_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cmd.div_start),
        .divisor    (n_reg),
        .dividend_a (DIV_W'(tsum_reg)),
        .dividend_b (DIV_W'(lsum_mag)),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .done       (div_done)
    );

    assign smoothed_rssi = smoothed_reg;
    assign latest_tx_pwr = latest_reg;
    assign mean_time     = mean_time_reg;
    assign samples_used  = used_reg;

    `BRWS_ASSERT_NOW(a_walk_bound, cmd.walk, issued_reg <= n_reg)
    `BRWS_ASSERT_NOW(a_setup_nonempty, cmd.setup, cnt_reg != '0)
    `BRWS_ASSERT_NEXT(a_sel_bound, cmd.setup, (n_reg != '0) && (n_reg <= cnt_reg))

endmodule

// ===== rtl/brws_ctrl.sv =====
`include "beacon_rssi_window_smoother_core_defines.svh"

module brws_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output brws_pkg::brws_cmd_t    cmd,
    input  brws_pkg::brws_status_t status
);
    import brws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   load_ok;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        load_ok        = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (load_ok)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `BRWS_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_reg || out_ready)
    `BRWS_ASSERT_NEXT(a_accept_setup, in_valid && in_ready, state_reg == S_SETUP)
    `BRWS_ASSERT_NOW(a_div_done_state, status.div_done, state_reg == S_DIV)
    `BRWS_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_reg && state_reg == S_IDLE)

endmodule

// ===== rtl/beacon_rssi_window_smoother_core.sv =====
// Beacon RSSI window smoother.
// Input channel (in_valid/in_ready): one measurement per transaction, tx_pwr,
// rssi (1/16 dBm, signed) and sample_time (ticks). Output channel
// (out_valid/out_ready): one result per input, the tx power minus the mean path
// loss over the newest n entries (saturated), that tx power, the truncated mean
// timestamp and n. Config channel (cfg_valid/cfg_ready/cfg_data) sets the window;
// 0 or a window wider than the history averages every stored entry. Write it
// only while the block is idle.
// Sequence from input accept to out_valid, where n is the number of entries
// averaged (1..64): a setup state; the history walk, which reads one entry a
// cycle through the single memory read port and then drains the read register;
// a bit-serial divider that produces one quotient bit per cycle of the 55-bit
// dividend (loss runs alongside); then the finish state loads the result.
// Only one measurement is in flight; in_ready is high only when the block is
// idle, so a new measurement is taken only after the previous result is loaded.
// Reset empties the history, zeroes the write pointer and sets the window to 0.
// A stalled receiver leaves the result parked in the output register; the next
// measurement is still taken and processed, then waits until the output is free.
module beacon_rssi_window_smoother_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [brws_pkg::PWR_W-1:0] tx_pwr,
    input  logic signed [brws_pkg::PWR_W-1:0] rssi,
    input  logic [brws_pkg::TIME_W-1:0]       sample_time,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [brws_pkg::PWR_W-1:0] smoothed_rssi,
    output logic signed [brws_pkg::PWR_W-1:0] latest_tx_pwr,
    output logic [brws_pkg::TIME_W-1:0]       mean_time,
    output logic [brws_pkg::WIN_W-1:0]        samples_used,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [brws_pkg::WIN_W-1:0]        cfg_data
);
    import brws_pkg::*;

    brws_cmd_t    cmd;
    brws_status_t status;

    // window register takes a write any cycle
    assign cfg_ready = 1'b1;

    brws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    brws_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .tx_pwr        (tx_pwr),
        .rssi          (rssi),
        .sample_time   (sample_time),
        .smoothed_rssi (smoothed_rssi),
        .latest_tx_pwr (latest_tx_pwr),
        .mean_time     (mean_time),
        .samples_used  (samples_used)
    );

endmodule

// ===== verif/beacon_rssi_window_smoother_core_tb.sv =====
`timescale 1ns / 1ps

module beacon_rssi_window_smoother_core_tb;

    localparam int PWR_W  = brws_pkg::PWR_W;
    localparam int TIME_W = brws_pkg::TIME_W;
    localparam int WIN_W  = brws_pkg::WIN_W;
    localparam int PTR_W  = brws_pkg::PTR_W;
    localparam int DEPTH  = brws_pkg::HISTORY_DEPTH;

    localparam int GAP_PCT      = 28;
    localparam int PHASE_ITEMS  = 82;
    localparam int SETTLE_TICKS = 150;   // longest walk plus divider, with margin

    // One beacon measurement as it goes onto the input channel.
    typedef struct packed {
        logic signed [PWR_W-1:0] tx;
        logic signed [PWR_W-1:0] rs;
        logic [TIME_W-1:0]       ts;
    } beacon_t;

    // One smoothed result as the block should report it.
    typedef struct {
        logic signed [PWR_W-1:0] level;
        logic signed [PWR_W-1:0] tx;
        logic [TIME_W-1:0]       mtime;
        logic [WIN_W-1:0]        used;
    } smooth_t;

    logic                     clk;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic signed [PWR_W-1:0]  tx_pwr      = '0;
    logic signed [PWR_W-1:0]  rssi        = '0;
    logic [TIME_W-1:0]        sample_time = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [PWR_W-1:0]  smoothed_rssi;
    logic signed [PWR_W-1:0]  latest_tx_pwr;
    logic [TIME_W-1:0]        mean_time;
    logic [WIN_W-1:0]         samples_used;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [WIN_W-1:0]         cfg_data    = '0;

    beacon_rssi_window_smoother_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .tx_pwr        (tx_pwr),
        .rssi          (rssi),
        .sample_time   (sample_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .smoothed_rssi (smoothed_rssi),
        .latest_tx_pwr (latest_tx_pwr),
        .mean_time     (mean_time),
        .samples_used  (samples_used),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run guard: ends a run that hangs and reports it as a mismatch.
    initial
    begin
        #10_000_000;
        $display("beacon_rssi_window_smoother_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the block's history and window register
    // ------------------------------------------------------------------
    logic signed [PWR_W:0]  loss_hist [DEPTH];   // tx - rssi, one bit wider
    logic [TIME_W-1:0]      stamp_hist [DEPTH];
    logic [PTR_W-1:0]       head     = '0;       // next slot to write
    int                     held     = 0;        // entries stored, saturates at DEPTH
    logic [WIN_W-1:0]       win_len  = '0;       // reset value of the window

    beacon_t                pending [$];         // measurements not yet on the wire
    smooth_t                expected [$];        // results still owed by the block
    int                     faults   = 0;
    logic                   gaps_on  = 1'b1;     // cleared for the steady stretch

    // Push one measurement into the shadow history and work out the result.
    function automatic smooth_t smooth_step(logic signed [PWR_W-1:0] tx,
                                            logic signed [PWR_W-1:0] rs,
                                            logic [TIME_W-1:0] ts);
        smooth_t          r;
        int               diff;
        int               n;
        logic [PTR_W-1:0] slot;
        longint           loss_acc;
        logic [63:0]      time_acc;
        longint           mean_loss;
        longint           level;
        diff = int'(tx) - int'(rs);
        loss_hist[head]  = diff[PWR_W:0];
        stamp_hist[head] = ts;
        head = head + 1'b1;
        if (held < DEPTH)
            held++;
        // window of zero, or wider than what is stored, takes every entry
        n = (win_len == 0 || int'(win_len) > held) ? held : int'(win_len);
        loss_acc = 0;
        time_acc = '0;
        for (int i = 0; i < n; i++)
        begin
            slot = head - PTR_W'(i + 1);
            loss_acc += longint'(loss_hist[slot]);
            time_acc += 64'(stamp_hist[slot]);
        end
        mean_loss = loss_acc / longint'(n);       // truncates toward zero
        level = longint'(tx) - mean_loss;
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        r.level = level[PWR_W-1:0];
        r.tx    = tx;
        r.mtime = 48'(time_acc / 64'(n));
        r.used  = n[WIN_W-1:0];
        return r;
    endfunction

    function automatic logic take_gap();
        return gaps_on && ($urandom_range(99) < GAP_PCT);
    endfunction

    function automatic logic [PWR_W-1:0] pick_corner();
        case ($urandom_range(6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            5: return 16'h5555;
            default: return 16'hAAAA;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: holds a transaction until it is taken, then maybe idles
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_proc
        logic    fire;
        beacon_t m;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
                expected.insert(expected.size(), smooth_step(tx_pwr, rssi, sample_time));
            if (in_valid && !fire)
            begin
                // payload stays put until accepted
            end
            else if (pending.size() > 0 && !take_gap())
            begin
                m = pending[0];
                pending.delete(0);
                in_valid    <= 1'b1;
                tx_pwr      <= m.tx;
                rssi        <= m.rs;
                sample_time <= m.ts;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compares each result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        smooth_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected result level=%0d tx=%0d time=%0d used=%0d",
                                 $realtime, smoothed_rssi, latest_tx_pwr, mean_time,
                                 samples_used);
                end
                else
                begin
                    want = expected[0];
                    expected.delete(0);
                    if (smoothed_rssi !== want.level || latest_tx_pwr !== want.tx ||
                        mean_time !== want.mtime || samples_used !== want.used)
                    begin
                        faults++;
                        if (faults <= 10)
                        begin
                            $display("%0t: exp level=%0d tx=%0d time=%0d used=%0d",
                                     $realtime, want.level, want.tx, want.mtime, want.used);
                            $display("%0t: got level=%0d tx=%0d time=%0d used=%0d",
                                     $realtime, smoothed_rssi, latest_tx_pwr, mean_time,
                                     samples_used);
                        end
                    end
                end
            end
            out_ready <= !take_gap();
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [PWR_W-1:0] tx, logic [PWR_W-1:0] rs,
                                       logic [TIME_W-1:0] ts);
        beacon_t b;
        b.tx = tx;
        b.rs = rs;
        b.ts = ts;
        pending.insert(pending.size(), b);
    endfunction

    // Window register: one transaction on the config channel, block idle.
    task automatic set_window(input logic [WIN_W-1:0] w);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = w;
    endtask

    // Wait until every queued measurement has gone in and every result is back.
    task automatic drain();
        @(posedge clk);
        while (pending.size() != 0 || in_valid || expected.size() != 0)
            @(posedge clk);
    endtask

    logic [WIN_W-1:0] windows [12] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd65, 7'd2,
                                       7'd63, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0};

    initial
    begin : stim_proc
        logic [TIME_W-1:0]       stamp;
        logic signed [PWR_W-1:0] tx;
        logic signed [PWR_W-1:0] rs;
        logic [TIME_W-1:0]       ts;
        stamp = 48'd1000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: window at its reset value, history filling from empty,
        // so the window of 0 averages everything stored throughout.
        queue_item(16'sd0, 16'sd0, 48'd0);
        queue_item(16'sh7FFF, 16'sh8000, 48'hFFFF_FFFF_FFFF);     // largest loss
        queue_item(16'sh8000, 16'sh7FFF, 48'hFFFF_FFFF_FFFF);     // smallest loss
        queue_item(16'sh8000, 16'sh7FFF, 48'hFFFF_FFFF_FFFE);
        queue_item(16'sh8000, 16'sh7FFF, 48'h8000_0000_0000);
        queue_item(16'sh7FFF, 16'sh7FFF, 48'h0000_0000_0001);     // saturates high
        queue_item(16'sh7FFF, 16'sh8000, 48'h5555_5555_5555);
        queue_item(16'sh7FFF, 16'sh8000, 48'hAAAA_AAAA_AAAA);
        queue_item(16'sh7FFF, 16'sh8000, 48'h0);
        queue_item(16'sh7FFF, 16'sh8000, 48'h0);
        queue_item(16'sh8000, 16'sh8000, 48'h0);                  // saturates low
        queue_item(16'shFFFF, 16'sh0000, 48'd7);                  // negative loss
        queue_item(16'shFFFE, 16'sh0000, 48'd8);
        queue_item(16'sh5555, 16'shAAAA, 48'h0000_FFFF_0000);
        queue_item(16'shAAAA, 16'sh5555, 48'hFFFF_0000_FFFF);
        queue_item(16'sh0001, 16'shFFFF, 48'd3);
        queue_item(-16'sd944, -16'sd1200, 48'd100);
        queue_item(-16'sd944, -16'sd1260, 48'd164);
        queue_item(-16'sd944, -16'sd1130, 48'd229);
        queue_item(-16'sd944, -16'sd1500, 48'd301);
        drain();

        // Random phases, each under its own window; later ones pick the window
        // at random. The history carries across phases and wraps many times.
        for (int p = 0; p < 12; p++)
        begin
            if (p >= 8)
                windows[p] = WIN_W'($urandom_range(127));
            set_window(windows[p]);
            gaps_on = (p != 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                    begin
                        // plausible beacon: tx from -75 to 25 dBm, rssi up to 100 dB below it, rising time
                        tx = PWR_W'(int'($urandom_range(1600)) - 1200);
                        rs = tx - PWR_W'($urandom_range(1600));
                        stamp = stamp + TIME_W'($urandom_range(5000, 1));
                        ts = stamp;
                    end
                    12, 13, 14, 15, 16:
                    begin
                        tx = PWR_W'($urandom);
                        rs = PWR_W'($urandom);
                        ts = TIME_W'({$urandom, $urandom});
                    end
                    default:
                    begin
                        tx = pick_corner();
                        rs = pick_corner();
                        ts = ($urandom_range(1) == 0) ? 48'hFFFF_FFFF_FFFF
                                                      : TIME_W'({$urandom, $urandom});
                    end
                endcase
                queue_item(tx, rs, ts);
            end
            drain();
        end
        gaps_on = 1'b1;

        repeat (SETTLE_TICKS) @(posedge clk);
        if (faults == 0 && expected.size() == 0)
            $display("beacon_rssi_window_smoother_core: match");
        else
            $display("beacon_rssi_window_smoother_core: mismatch");
        $finish;
    end

endmodule

// ===== beacon_rssi_window_smoother_core.f =====
+incdir+rtl
rtl/brws_pkg.sv
rtl/brws_div.sv
rtl/brws_dp.sv
rtl/brws_ctrl.sv
rtl/beacon_rssi_window_smoother_core.sv
verif/beacon_rssi_window_smoother_core_tb.sv
